[hdl/skyatl_pkg.sv]
// shared constants, widths and controller/datapath interface types
// for the skyline atlas allocator; no dependencies

package skyatl_pkg;

  // geometry of the atlas
  localparam int PAGES       = 2;
  localparam int PAGE_WIDTH  = 256;
  localparam int PAGE_HEIGHT = 256;

  localparam int COL_TOTAL = PAGES * PAGE_WIDTH;

  // fixed field widths of the request and result
  localparam int RECT_W    = 9;
  localparam int PAGEIDX_W = 1;
  localparam int X_W       = 8;
  localparam int Y_W       = 8;

  // internal widths that follow from the geometry
  localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int COL_W  = $clog2(PAGE_WIDTH);
  localparam int CNT_W  = $clog2(PAGE_WIDTH + 1);
  localparam int HGT_W  = $clog2(PAGE_HEIGHT + 1);
  localparam int ADDR_W = $clog2(COL_TOTAL);
  localparam int LEN_W  = ((RECT_W > CNT_W) ? RECT_W : CNT_W) + 1;
  localparam int SUM_W  = ((RECT_W > HGT_W) ? RECT_W : HGT_W) + 1;

  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(PAGE_WIDTH - 1);
  localparam logic [PG_W-1:0]  LAST_PAGE = PG_W'(PAGES - 1);

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_FWD,
    OP_REV,
    OP_FILL
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e          op;
    logic             first;
    logic [PG_W-1:0]  page;
    logic [COL_W-1:0] col;
    logic             load_req;
    logic             load_res;
    logic             placed;
  } skyatl_cmd_t;

  typedef struct packed {
    logic req_bad;
    logic fits;
    logic fill_last;
  } skyatl_sts_t;

endpackage

[hdl/skyline_atlas_allocator_unit.sv]
// top level of the skyline atlas allocator: sequencer and datapath
// depends on skyatl_pkg, skyatl_ctrl and skyatl_datapath
//
//   channel | handshake                  | payload
//   --------+----------------------------+------------------------------------------
//   request | in_valid_i / in_ready_o    | rect_width_i, rect_height_i
//   result  | out_valid_o / out_ready_i  | placed_o, page_index_o, x_pos_o, y_pos_o
//
// after reset a clearing pass zeroes the column store, with no request taken. each
// page tried costs a forward pass building block maxima and a reverse pass finding
// the lowest spot, each one column read a cycle from the single-port store; a
// placement adds a fill pass over rect_width columns. one request is in work at a
// time; a finished result waits in its register while the next request is taken,
// and a stalled result only holds the sequencer when the following one is ready.

module skyline_atlas_allocator_unit import skyatl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [RECT_W-1:0]    rect_width_i,
  input  logic [RECT_W-1:0]    rect_height_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 placed_o,
  output logic [PAGEIDX_W-1:0] page_index_o,
  output logic [X_W-1:0]       x_pos_o,
  output logic [Y_W-1:0]       y_pos_o
);

  skyatl_cmd_t cmd;
  skyatl_sts_t sts;

  skyatl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  skyatl_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .placed_o      (placed_o),
    .page_index_o  (page_index_o),
    .x_pos_o       (x_pos_o),
    .y_pos_o       (y_pos_o)
  );

endmodule

[hdl/skyatl_datapath.sv]
// column height store, block maximum scratch store, window search and
// result registers of the skyline atlas allocator; uses skyatl_pkg

module skyatl_datapath import skyatl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skyatl_cmd_t       cmd_i,
  output skyatl_sts_t       sts_o,
  input  logic [RECT_W-1:0] rect_width_i,
  input  logic [RECT_W-1:0] rect_height_i,
  output logic              placed_o,
  output logic [PAGEIDX_W-1:0] page_index_o,
  output logic [X_W-1:0]    x_pos_o,
  output logic [Y_W-1:0]    y_pos_o
);

  function automatic logic [HGT_W-1:0] hmax(input logic [HGT_W-1:0] a,
                                            input logic [HGT_W-1:0] b);
    hmax = (a > b) ? a : b;
  endfunction

  logic [HGT_W-1:0] col_mem [COL_TOTAL];
  logic [HGT_W-1:0] scr_mem [PAGE_WIDTH];

  logic [RECT_W-1:0] w_q, h_q;
  logic [HGT_W-1:0]  col_rd_q, scr_rd_q;

  // read-data stage tags
  cmd_op_e          op_q;
  logic             first_q;
  logic [COL_W-1:0] stg_col_q;
  logic             winok_q;

  logic [COL_W-1:0] pos_q, pos_d;
  logic [HGT_W-1:0] pre_q, pre_d;
  logic [HGT_W-1:0] g_q, g_d;
  logic [HGT_W-1:0] best_q, best_d, best_base;
  logic [COL_W-1:0] bestx_q, bestx_d;
  logic             found_q, found_d, found_base;
  logic [HGT_W-1:0] win_max;
  logic             take;

  logic             res_placed_q;
  logic [PAGEIDX_W-1:0] res_page_q;
  logic [X_W-1:0]   res_x_q;
  logic [Y_W-1:0]   res_y_q;

  logic [COL_W-1:0]  wlast;
  logic              win_ok;
  logic [COL_W-1:0]  scr_raddr;
  logic [COL_W-1:0]  fill_col;
  logic [COL_W-1:0]  acc_col;
  logic [ADDR_W-1:0] mem_addr;
  logic [SUM_W-1:0]  top_sum;
  logic [HGT_W-1:0]  fill_val;

  assign wlast     = COL_W'(w_q - 1'b1);
  assign win_ok    = (LEN_W'(cmd_i.col) + LEN_W'(w_q)) <= LEN_W'(PAGE_WIDTH);
  assign scr_raddr = COL_W'(LEN_W'(cmd_i.col) + LEN_W'(w_q) - 1'b1);
  assign fill_col  = COL_W'(bestx_q + cmd_i.col);
  assign acc_col   = (cmd_i.op == OP_FILL) ? fill_col : cmd_i.col;
  assign mem_addr  = ADDR_W'(ADDR_W'(cmd_i.page) * ADDR_W'(PAGE_WIDTH) + ADDR_W'(acc_col));
  assign top_sum   = SUM_W'(best_q) + SUM_W'(h_q);
  assign fill_val  = HGT_W'(top_sum);

  assign sts_o.req_bad   = (w_q == '0) || (h_q == '0) ||
                           (LEN_W'(w_q) > LEN_W'(PAGE_WIDTH));
  assign sts_o.fits      = found_q && (top_sum <= SUM_W'(PAGE_HEIGHT));
  assign sts_o.fill_last = (LEN_W'(cmd_i.col) + 1'b1) == LEN_W'(w_q);

  // window search on the data read in the previous cycle
  always_comb begin
    pos_d      = pos_q;
    pre_d      = pre_q;
    g_d        = g_q;
    best_base  = first_q ? HGT_W'(PAGE_HEIGHT) : best_q;
    found_base = first_q ? 1'b0 : found_q;
    best_d     = best_q;
    bestx_d    = bestx_q;
    found_d    = found_q;
    win_max    = '0;
    take       = 1'b0;
    case (op_q)
      OP_FWD: begin
        // running maximum from the start of each block of w columns
        if (first_q || pos_q == wlast) begin
          pos_d = '0;
          pre_d = col_rd_q;
        end else begin
          pos_d = pos_q + 1'b1;
          pre_d = hmax(pre_q, col_rd_q);
        end
      end
      OP_REV: begin
        // running maximum back to the end of each block
        if (first_q) begin
          g_d = col_rd_q;
        end else if (pos_q == '0) begin
          pos_d = wlast;
          g_d   = col_rd_q;
        end else begin
          pos_d = pos_q - 1'b1;
          g_d   = hmax(g_q, col_rd_q);
        end
        win_max = hmax(g_d, scr_rd_q);
        // right to left, so ties move the pick further left
        take    = winok_q && (win_max < HGT_W'(PAGE_HEIGHT)) && (win_max <= best_base);
        best_d  = take ? win_max : best_base;
        bestx_d = take ? stg_col_q : bestx_q;
        found_d = found_base | take;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_NONE;
      found_q <= 1'b0;
    end else begin
      op_q    <= cmd_i.op;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q   <= cmd_i.first;
    stg_col_q <= cmd_i.col;
    winok_q   <= win_ok;
    pos_q     <= pos_d;
    pre_q     <= pre_d;
    g_q       <= g_d;
    best_q    <= best_d;
    bestx_q   <= bestx_d;
    if (cmd_i.load_req) begin
      w_q <= rect_width_i;
      h_q <= rect_height_i;
    end
    if (cmd_i.load_res) begin
      res_placed_q <= cmd_i.placed;
      res_page_q   <= cmd_i.placed ? PAGEIDX_W'(cmd_i.page) : '0;
      res_x_q      <= cmd_i.placed ? X_W'(bestx_q) : '0;
      res_y_q      <= cmd_i.placed ? Y_W'(best_q) : '0;
    end
  end

  // column height store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CLEAR) begin
      col_mem[mem_addr] <= '0;
    end else if (cmd_i.op == OP_FILL) begin
      col_mem[mem_addr] <= fill_val;
    end
    if (cmd_i.op == OP_FWD || cmd_i.op == OP_REV) begin
      col_rd_q <= col_mem[mem_addr];
    end
  end

  // block prefix maxima of the page under scan
  always_ff @(posedge clk_i) begin
    if (op_q == OP_FWD) begin
      scr_mem[stg_col_q] <= pre_d;
    end
    if (cmd_i.op == OP_REV) begin
      scr_rd_q <= scr_mem[scr_raddr];
    end
  end

  assign placed_o     = res_placed_q;
  assign page_index_o = res_page_q;
  assign x_pos_o      = res_x_q;
  assign y_pos_o      = res_y_q;

endmodule

[hdl/skyatl_ctrl.sv]
// sequencer of the skyline atlas allocator: clearing pass, per-page
// forward and reverse scans, column fill and result hand-off; uses skyatl_pkg

module skyatl_ctrl import skyatl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  skyatl_sts_t sts_i,
  output skyatl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_FWD,
    S_TURN,
    S_REV,
    S_DRAIN,
    S_DECIDE,
    S_FILL,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [COL_W-1:0] col_q;
  logic [PG_W-1:0]  page_q;
  logic             placed_q;
  logic             out_valid_q;
  logic             res_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign res_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      S_CLEAR: cmd_o.op = OP_CLEAR;
      S_FWD:   cmd_o.op = OP_FWD;
      S_REV:   cmd_o.op = OP_REV;
      S_FILL:  cmd_o.op = OP_FILL;
      default: cmd_o.op = OP_NONE;
    endcase
    cmd_o.first    = ((state_q == S_FWD) && (col_q == '0)) ||
                     ((state_q == S_REV) && (col_q == LAST_COL));
    cmd_o.page     = page_q;
    cmd_o.col      = col_q;
    cmd_o.load_req = in_valid_i && in_ready_o;
    cmd_o.load_res = (state_q == S_DONE) && res_free;
    cmd_o.placed   = placed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      col_q       <= '0;
      page_q      <= '0;
      placed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && res_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (col_q == LAST_COL) begin
            col_q <= '0;
            if (page_q == LAST_PAGE) begin
              page_q  <= '0;
              state_q <= S_IDLE;
            end else begin
              page_q <= page_q + 1'b1;
            end
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          page_q <= '0;
          col_q  <= '0;
          if (sts_i.req_bad) begin
            placed_q <= 1'b0;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_FWD;
          end
        end
        S_FWD: begin
          if (col_q == LAST_COL) begin
            state_q <= S_TURN;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
        // an idle state so the last prefix write lands before reverse reads
        S_TURN: state_q <= S_REV;
        S_REV: begin
          if (col_q == '0) begin
            state_q <= S_DRAIN;
          end else begin
            col_q <= col_q - 1'b1;
          end
        end
        S_DRAIN: state_q <= S_DECIDE;
        S_DECIDE: begin
          col_q <= '0;
          if (sts_i.fits) begin
            state_q <= S_FILL;
          end else if (page_q == LAST_PAGE) begin
            placed_q <= 1'b0;
            state_q  <= S_DONE;
          end else begin
            page_q  <= page_q + 1'b1;
            state_q <= S_FWD;
          end
        end
        S_FILL: begin
          if (sts_i.fill_last) begin
            placed_q <= 1'b1;
            state_q  <= S_DONE;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
        S_DONE: begin
          if (res_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
